/* src/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-, word- and round-level functions for the AES block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_KEY_LEN  = 3'd4,
        REG_MODE     = 3'd5,
        REG_IV_LOW   = 3'd6,
        REG_IV_HIGH  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_FWD,
        ST_KEY_INV,
        ST_READY,
        ST_RUN
    } state_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // forward mix column, byte r of the column in bits 8r+7:8r
    function automatic logic [31:0] mix_fwd(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] b [4];
        logic [31:0] res;
        for (int r = 0; r < 4; r++) begin
            a[r] = w[8*r +: 8];
            b[r] = xtime(a[r]);
        end
        for (int r = 0; r < 4; r++) begin
            res[8*r +: 8] = b[r] ^ b[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
        return res;
    endfunction

    // inverse mix column, coefficients 14 11 13 9
    function automatic logic [31:0] mix_inv(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [31:0] res;
        for (int r = 0; r < 4; r++) begin
            a[r]  = w[8*r +: 8];
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
        end
        for (int r = 0; r < 4; r++) begin
            res[8*r +: 8] = (x8[r] ^ x4[r] ^ x2[r])
                          ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                          ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                          ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        return res;
    endfunction

    // one encryption round body without key add; the last round skips mix columns
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[32*c +: 32] = mix_fwd(t[32*c +: 32]);
        end
        return last ? t : m;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(4*((c+r)%4)+r) +: 8] = INV_SBOX[s[8*(4*c+r) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[32*c +: 32] = mix_inv(t[32*c +: 32]);
        end
        return last ? t : m;
    endfunction

endpackage

`default_nettype wire

/* src/aes_block_cipher_ecb_cbc.sv */
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc
// AES-128/192/256 block cipher, ECB or CBC, one 16-byte block per transfer.
// ----------------------------------------------------------------------------
// Usage: write key, key length, mode and IV through the cfg port while idle.
// s_ channel: one block per transfer, tuser selects decrypt and restart.
// m_ channel: one result block per input block, in order.
// When the block leaves idle (first input seen after reset or after a config
// write made outside a running block), it expands the key into the round key
// memories: first the forward schedule, then the inverse keys. After that
// each block is taken and added to round key 0 in the ready state, then runs
// Nr rounds (10, 12 or 14) in the single round unit that reads one 128-bit
// round key row per cycle while the loop is not stalled. Keys are re-expanded
// only after a config write. The result sits in an output register; the next
// block is taken while it waits, and the loop stalls in its last round only
// if the receiver has not yet taken the previous one.
// Reset is synchronous, active low; it reloads the chaining value from the
// IV reset value (zero) and marks the keys as stale.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_ecb_cbc
    import aes_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [127:0]          s_tdata,  // block_low, block_high
    input  wire logic [1:0]            s_tuser,  // operation, restart_chain
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [127:0]          m_tdata   // result_low, result_high
);

    // configuration registers
    logic [255:0] key_reg;
    logic [1:0]   key_len_reg;
    logic         mode_reg;
    logic [127:0] iv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            key_len_reg <= '0;
            mode_reg    <= 1'b0;
            iv_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY0:    key_reg[63:0]    <= cfg_data[63:0];
                REG_KEY1:    key_reg[127:64]  <= cfg_data[63:0];
                REG_KEY2:    key_reg[191:128] <= cfg_data[63:0];
                REG_KEY3:    key_reg[255:192] <= cfg_data[63:0];
                REG_KEY_LEN: key_len_reg      <= cfg_data[1:0];
                REG_MODE:    mode_reg         <= cfg_data[0];
                REG_IV_LOW:  iv_reg[63:0]     <= cfg_data[63:0];
                REG_IV_HIGH: iv_reg[127:64]   <= cfg_data[63:0];
                default: ;
            endcase
        end
    end

    logic [3:0] nr;
    logic [3:0] nk;
    logic [5:0] total;
    always_comb begin
        case (key_len_reg)
            2'd0:    begin nr = 4'd10; nk = 4'd4; end
            2'd1:    begin nr = 4'd12; nk = 4'd6; end
            default: begin nr = 4'd14; nk = 4'd8; end
        endcase
        total = {nr, 2'b00} + 6'd4;
    end

    // round key memories, 128-bit rows read per round, word-written
    logic [127:0] ek_mem [15];
    logic [127:0] dk_mem [15];

    state_t      state_reg, state_next;
    logic [5:0]  widx_reg;      // key word index
    logic [3:0]  rc_mod_reg;    // i mod nk
    logic [7:0]  rcon_reg;
    logic [255:0] win_reg;      // last eight schedule words, newest at top
    logic [3:0]  rnd_reg;
    logic [127:0] st_reg;
    logic [127:0] cv_reg;
    logic [127:0] blk_reg;      // input block kept for CBC decrypt
    logic        op_reg;
    logic [127:0] out_reg;
    logic        out_vld_reg;

    // key expansion, one word per cycle
    logic [31:0] prev_w, old_w, t_w, new_w;
    always_comb begin
        prev_w = win_reg[255:224];
        case (nk)
            4'd4:    old_w = win_reg[159:128];
            4'd6:    old_w = win_reg[95:64];
            default: old_w = win_reg[31:0];
        endcase
        t_w = prev_w;
        if (rc_mod_reg == 4'd0) begin
            t_w = sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'd0, rcon_reg};
        end else if (nk == 4'd8 && rc_mod_reg == 4'd4) begin
            t_w = sub_word(prev_w);
        end
        if (widx_reg < {2'b00, nk}) begin
            new_w = key_reg[32*widx_reg[2:0] +: 32];
        end else begin
            new_w = old_w ^ t_w;
        end
    end

    // inverse key pass: read encryption word, write transformed word
    logic [31:0] ek_rd_reg;
    logic [5:0]  dk_idx_reg;
    logic        dk_we_reg;
    logic        dk_plain_reg;
    logic [5:0]  src_row;
    always_comb begin
        // destination row j gets encryption row nr-j
        src_row = {2'b00, nr} - {2'b00, widx_reg[5:2]};
    end

    logic in_fire;
    logic last_rnd;
    logic done;
    logic take;
    logic [127:0] cv_use;
    assign last_rnd = (rnd_reg == nr);
    assign done     = (state_reg == ST_RUN) && last_rnd && (!out_vld_reg || m_tready);
    // take a new block only when the round unit is free and no config write is seen
    assign take     = (state_reg == ST_READY) && !cfg_we;
    assign s_tready = take;
    assign in_fire  = s_tvalid && take;
    assign cv_use   = s_tuser[1] ? iv_reg : cv_reg;

    // round loop: read one row per cycle unless the last round stalls, row 0 waits in the row register while ready
    logic [3:0]  key_row;
    logic [127:0] ek_row_reg, dk_row_reg;
    always_comb begin
        if (state_reg == ST_RUN) begin
            if (!last_rnd) key_row = rnd_reg + 4'd1;
            else if (done) key_row = 4'd0;
            else key_row = nr;  // hold the last row while the result waits
        end else begin
            key_row = in_fire ? 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        ek_row_reg <= ek_mem[key_row];
        dk_row_reg <= dk_mem[key_row];
        if (state_reg == ST_KEY_INV && widx_reg < total) begin
            ek_rd_reg <= ek_mem[src_row[3:0]][32*widx_reg[1:0] +: 32];
        end
        if (state_reg == ST_KEY_FWD) begin
            ek_mem[widx_reg[5:2]][32*widx_reg[1:0] +: 32] <= new_w;
        end
        if (dk_we_reg) begin
            dk_mem[dk_idx_reg[5:2]][32*dk_idx_reg[1:0] +: 32] <=
                dk_plain_reg ? ek_rd_reg : mix_inv(ek_rd_reg);
        end
    end

    logic [127:0] add_in;
    logic [127:0] rnd_out;
    always_comb begin
        add_in = op_reg ? dec_round(st_reg, last_rnd) : enc_round(st_reg, last_rnd);
        rnd_out = add_in ^ (op_reg ? dk_row_reg : ek_row_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_KEY_FWD;
            ST_KEY_FWD: if (cfg_we) state_next = ST_IDLE;
                        else if (widx_reg == total - 6'd1) state_next = ST_KEY_INV;
            ST_KEY_INV: if (cfg_we) state_next = ST_IDLE;
                        else if (widx_reg == total + 6'd1) state_next = ST_READY;
            ST_READY:   if (cfg_we) state_next = ST_IDLE;
                        else if (in_fire) state_next = ST_RUN;
            ST_RUN:     if (done) state_next = ST_READY;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cv_reg      <= '0;
            out_vld_reg <= 1'b0;
            dk_we_reg   <= 1'b0;
            widx_reg    <= '0;
        end else begin
            state_reg <= state_next;
            dk_we_reg <= 1'b0;
            if (m_tready) out_vld_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    widx_reg   <= '0;
                    rc_mod_reg <= '0;
                    rcon_reg   <= 8'h01;
                end
                ST_KEY_FWD: begin
                    win_reg <= {new_w, win_reg[255:32]};
                    if (widx_reg == total - 6'd1) begin
                        widx_reg <= '0;
                    end else begin
                        widx_reg <= widx_reg + 6'd1;
                    end
                    if (rc_mod_reg == nk - 4'd1) begin
                        rc_mod_reg <= '0;
                    end else begin
                        rc_mod_reg <= rc_mod_reg + 4'd1;
                    end
                    if (rc_mod_reg == 4'd0 && widx_reg != 6'd0) begin
                        rcon_reg <= xtime(rcon_reg);
                    end
                end
                ST_KEY_INV: begin
                    widx_reg <= widx_reg + 6'd1;
                    if (widx_reg < total) begin
                        dk_we_reg    <= 1'b1;
                        dk_idx_reg   <= widx_reg;
                        dk_plain_reg <= (widx_reg[5:2] == 4'd0) || (widx_reg[5:2] == nr);
                    end
                end
                ST_READY: begin
                    if (in_fire) begin
                        op_reg  <= s_tuser[0];
                        blk_reg <= s_tdata;
                        rnd_reg <= 4'd1;
                        if (s_tuser[1]) cv_reg <= iv_reg;
                        if (mode_reg && s_tuser[0] == OP_ENCRYPT) begin
                            st_reg <= s_tdata ^ cv_use ^ ek_row_reg;
                        end else if (s_tuser[0] == OP_ENCRYPT) begin
                            st_reg <= s_tdata ^ ek_row_reg;
                        end else begin
                            st_reg <= s_tdata ^ dk_row_reg;
                        end
                    end
                end
                ST_RUN: begin
                    if (!last_rnd) begin
                        st_reg  <= rnd_out;
                        rnd_reg <= rnd_reg + 4'd1;
                    end else if (done) begin
                        out_vld_reg <= 1'b1;
                        if (mode_reg) begin
                            if (op_reg == OP_ENCRYPT) begin
                                out_reg <= rnd_out;
                                cv_reg  <= rnd_out;
                            end else begin
                                out_reg <= rnd_out ^ cv_reg;
                                cv_reg  <= blk_reg;
                            end
                        end else begin
                            out_reg <= rnd_out;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

/* verif/aes_block_cipher_ecb_cbc_tb.sv */
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc_tb
// Self-checking bench for the AES ECB/CBC block cipher: a table of directed
// blocks, then random traffic, each result checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aes_block_cipher_ecb_cbc_tb;
    import aes_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // block_low, block_high
    logic [1:0]   s_tuser;   // operation, restart_chain
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // result_low, result_high

    aes_block_cipher_ecb_cbc dut (.*);

    logic [63:0]  shadow_regs [8];
    logic [127:0] chain_reg;
    logic [31:0]  ek [60];
    logic [31:0]  dk [60];
    logic [127:0] expected_blocks [$];
    int           error_count;
    int           stall_max;
    int           rx_wait = 0;
    logic         tx_active;

    typedef struct {
        logic         op;
        logic         restart;
        logic [127:0] blk;
        logic         known;
        logic [127:0] result;
    } vector_t;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] gf2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = gf2(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] v);
        for (int i = 0; i < 256; i++) if (SBOX[i] == v) return i[7:0];
        return 8'h00;
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] w, input logic inv);
        logic [7:0] a [4];
        logic [7:0] c [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) a[i] = w[8*i +: 8];
        if (inv) begin
            c[0] = 8'd14; c[1] = 8'd11; c[2] = 8'd13; c[3] = 8'd9;
        end else begin
            c[0] = 8'd2; c[1] = 8'd3; c[2] = 8'd1; c[3] = 8'd1;
        end
        for (int i = 0; i < 4; i++)
            r[8*i +: 8] = gfmul(a[i], c[0]) ^ gfmul(a[(i+1)%4], c[1])
                        ^ gfmul(a[(i+2)%4], c[2]) ^ gfmul(a[(i+3)%4], c[3]);
        return r;
    endfunction

    function automatic int rounds_now();
        int k;
        k = int'(shadow_regs[REG_KEY_LEN][1:0]);
        if (k > 2) k = 2;
        return 10 + 2 * k;
    endfunction

    function automatic void schedule_keys(input int nr);
        int nk;
        logic [31:0] t;
        logic [7:0] rc;
        nk = nr - 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++) ek[i] = shadow_regs[i/2][32*(i%2) +: 32];
        for (int i = nk; i < 4*(nr+1); i++) begin
            t = ek[i-1];
            if (i % nk == 0) begin
                t = {SBOX[t[7:0]], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]]}
                    ^ {24'h0, rc};
                rc = gf2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            end
            ek[i] = ek[i-nk] ^ t;
        end
        for (int c = 0; c < 4; c++) begin
            dk[c] = ek[4*nr+c];
            dk[4*nr+c] = ek[c];
        end
        for (int j = 1; j < nr; j++)
            for (int c = 0; c < 4; c++) dk[4*j+c] = mix_column(ek[4*(nr-j)+c], 1'b1);
    endfunction

    function automatic logic [127:0] round_key(input int rnd, input logic inv);
        logic [127:0] k;
        for (int c = 0; c < 4; c++) k[32*c +: 32] = inv ? dk[4*rnd+c] : ek[4*rnd+c];
        return k;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] s, input logic inv,
                                                  input int nr);
        logic [127:0] t;
        s ^= round_key(0, inv);
        for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    if (inv) t[8*(4*((c+r)%4)+r) +: 8] = inv_sub(s[8*(4*c+r) +: 8]);
                    else t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
            if (rnd != nr)
                for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_column(t[32*c +: 32], inv);
            s = t ^ round_key(rnd, inv);
        end
        return s;
    endfunction

    function automatic logic [127:0] predict_block(input logic op, input logic restart,
                                                   input logic [127:0] blk);
        int nr;
        logic cbc;
        logic [127:0] s;
        nr = rounds_now();
        cbc = shadow_regs[REG_MODE][0];
        schedule_keys(nr);
        if (restart) chain_reg = {shadow_regs[REG_IV_HIGH], shadow_regs[REG_IV_LOW]};
        if (op == OP_ENCRYPT) begin
            s = cipher_block(cbc ? blk ^ chain_reg : blk, 1'b0, nr);
            if (cbc) chain_reg = s;
        end else begin
            s = cipher_block(blk, 1'b1, nr);
            if (cbc) begin
                s ^= chain_reg;
                chain_reg = blk;
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [127:0] got,
                                   input logic [127:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_LEN) val &= 64'h3;
        if (idx == REG_MODE) val &= 64'h1;
        shadow_regs[idx] = val;
    endtask

    // drop tvalid once after the last accepted transfer
    task automatic stop_input();
        if (tx_active) begin
            s_tvalid <= 1'b0;
            tx_active = 1'b0;
        end
    endtask

    task automatic drain_results();
        stop_input();
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic drive_block(input logic op, input logic restart, input logic [127:0] blk,
                               input logic [127:0] want, input int gap);
        if (gap > 0) begin
            stop_input();
            repeat (gap) @(posedge aclk);
        end
        expected_blocks.push_back(want);
        s_tvalid <= 1'b1;
        s_tdata <= blk;
        s_tuser <= {restart, op};
        tx_active = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_block(input logic op, input logic restart, input logic [127:0] blk,
                              input int gap);
        drive_block(op, restart, blk, predict_block(op, restart, blk), gap);
    endtask

    // result side, a random wait drawn after each transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected transfer", m_tdata, 128'h0);
                end else begin
                    logic [127:0] want;
                    want = expected_blocks.pop_front();
                    if (m_tdata[63:0] !== want[63:0])
                        report_mismatch("result_low", m_tdata, want);
                    if (m_tdata[127:64] !== want[127:64])
                        report_mismatch("result_high", m_tdata, want);
                end
                rx_wait = (stall_max == 0) ? 0 : int'($urandom_range(0, stall_max));
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    vector_t directed [] = '{
        // zero key, zero block after reset: known AES-128 vector
        '{OP_ENCRYPT, 1'b0, 128'h0, 1'b1, 128'h2e2b34ca59fa4c883b2c8aefd44be966},
        '{OP_DECRYPT, 1'b0, 128'h2e2b34ca59fa4c883b2c8aefd44be966, 1'b1, 128'h0},
        '{OP_ENCRYPT, 1'b1, '1, 1'b0, 128'h0},
        '{OP_DECRYPT, 1'b1, '1, 1'b0, 128'h0},
        '{OP_ENCRYPT, 1'b0, 128'h00000000000000010000000000000000, 1'b0, 128'h0},
        '{OP_DECRYPT, 1'b0, 128'h80000000000000000000000000000000, 1'b0, 128'h0}
    };

    initial begin
        logic op, rs;
        int gap;
        error_count = 0;
        stall_max = 0;
        tx_active = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        for (int i = 0; i < 8; i++) shadow_regs[i] = '0;
        chain_reg = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each key length, ECB then CBC, extreme keys
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                drain_results();
                write_reg(REG_KEY0, phase[0] ? '1 : 64'h0706050403020100);
                write_reg(REG_KEY1, phase[0] ? '1 : 64'h0f0e0d0c0b0a0908);
                write_reg(REG_KEY2, phase[0] ? '1 : 64'h1716151413121110);
                write_reg(REG_KEY3, phase[0] ? '1 : 64'h1f1e1d1c1b1a1918);
                write_reg(REG_KEY_LEN, 64'(phase));
                write_reg(REG_MODE, 64'(phase > 1));
                write_reg(REG_IV_LOW, phase[0] ? '1 : 64'h0);
                write_reg(REG_IV_HIGH, phase[0] ? '1 : 64'h0);
            end
            foreach (directed[i]) begin
                if (phase == 0 && directed[i].known) begin
                    logic [127:0] got;
                    got = predict_block(directed[i].op, directed[i].restart,
                                        directed[i].blk);
                    if (got !== directed[i].result)
                        report_mismatch("table entry", got, directed[i].result);
                    drive_block(directed[i].op, directed[i].restart, directed[i].blk,
                                directed[i].result, 0);
                end else begin
                    send_block(directed[i].op, directed[i].restart, directed[i].blk, 0);
                end
            end
        end

        // random phases with fresh settings, mostly CBC streams
        for (int phase = 0; phase < 20; phase++) begin
            drain_results();
            write_reg(REG_KEY0, edge64());
            write_reg(REG_KEY1, edge64());
            write_reg(REG_KEY2, edge64());
            write_reg(REG_KEY3, edge64());
            write_reg(REG_KEY_LEN, 64'($urandom_range(0, 3)));
            write_reg(REG_MODE, 64'($urandom_range(0, 3) != 0));
            write_reg(REG_IV_LOW, edge64());
            write_reg(REG_IV_HIGH, edge64());
            stall_max = (phase % 3 == 0) ? 0 : int'($urandom_range(0, 14));
            for (int n = 0; n < 48; n++) begin
                op = 1'($urandom_range(0, 1));
                rs = (n == 0) || ($urandom_range(0, 9) == 0);
                gap = (phase % 4 == 1) ? 0 : int'($urandom_range(0, 14));
                if (n == 24) begin
                    stop_input();
                    while (expected_blocks.size() != 0) @(posedge aclk);
                end
                send_block(op, rs, {edge64(), edge64()}, gap);
            end
        end

        stall_max = 0;
        drain_results();
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/aes_pkg.sv
src/aes_block_cipher_ecb_cbc.sv
verif/aes_block_cipher_ecb_cbc_tb.sv
